>>> design/dltp_pkg.sv
// Shared types, command codes and texture field encoding for the display list texture patcher.
package dltp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned MARK_W     = 5;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    // Command opcodes.
    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_CMD6      = 8'h08;
    localparam logic [7:0] OP_CMD9      = 8'h10;
    localparam logic [7:0] OP_REG_WRITE = 8'h61;

    // Bytes still owed after each opcode.
    localparam logic [3:0] LEN_CMD6      = 4'd5;
    localparam logic [3:0] LEN_CMD9      = 4'd8;
    localparam logic [3:0] LEN_REG_WRITE = 4'd4;
    localparam logic [3:0] POS_REG_ID    = 4'd4;
    localparam logic [3:0] POS_PAYLOAD   = 4'd3;

    // Register identifiers within register writes.
    localparam logic [7:0] REG_TEX_SIZE = 8'h88;
    localparam logic [7:0] REG_TEX_ZERO = 8'h84;
    localparam logic [7:0] REG_TEX_ADDR = 8'h94;
    localparam logic [7:0] REG_WRAP_S   = 8'h30;
    localparam logic [7:0] REG_WRAP_T   = 8'h31;
    localparam logic [7:0] REG_STOP     = 8'h80;

    // Patch mark bit positions.
    localparam int unsigned MARK_TEX_SIZE = 0;
    localparam int unsigned MARK_TEX_ADDR = 1;
    localparam int unsigned MARK_WRAP_S   = 2;
    localparam int unsigned MARK_WRAP_T   = 3;
    localparam int unsigned MARK_TEX_ZERO = 4;

    localparam logic [31:0] ADDR_CLEAR_MASK = 32'h3000_0000;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TEX_FORMAT    = 3'd0;
    localparam logic [2:0] CFG_TEX_WIDTH     = 3'd1;
    localparam logic [2:0] CFG_TEX_HEIGHT    = 3'd2;
    localparam logic [2:0] CFG_IMAGE_ADDRESS = 3'd3;
    localparam logic [2:0] CFG_WRAP_S_MODE   = 3'd4;
    localparam logic [2:0] CFG_WRAP_T_MODE   = 3'd5;

    typedef struct packed {
        logic [3:0]  tex_format;
        logic [10:0] tex_width;
        logic [10:0] tex_height;
        logic [31:0] image_address;
        logic [7:0]  wrap_s_mode;
        logic [7:0]  wrap_t_mode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] patched_byte;
        logic       was_rewritten;
        logic       ends_here;
        logic       after_end;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_patch;

    // Mark bit set by a register write to the given register.
    function automatic logic [MARK_W-1:0] mark_of(input logic [7:0] reg_id);
        logic [MARK_W-1:0] m;
        m = '0;
        case (reg_id)
            REG_TEX_SIZE: m[MARK_TEX_SIZE] = 1'b1;
            REG_TEX_ADDR: m[MARK_TEX_ADDR] = 1'b1;
            REG_WRAP_S:   m[MARK_WRAP_S]   = 1'b1;
            REG_WRAP_T:   m[MARK_WRAP_T]   = 1'b1;
            REG_TEX_ZERO: m[MARK_TEX_ZERO] = 1'b1;
            default:      m = '0;
        endcase
        return m;
    endfunction

    // Replacement payload byte idx of a register write, with a flag for a patched register.
    function automatic t_patch payload_byte(input t_cfg cfg, input logic [7:0] reg_id,
                                            input logic [1:0] idx);
        logic [9:0]  w;
        logic [9:0]  h;
        logic [19:0] s;
        logic [31:0] a;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        t_patch      p;
        w  = cfg.tex_width[9:0] - 10'd1;
        h  = cfg.tex_height[9:0] - 10'd1;
        s  = {h, w};
        a  = cfg.image_address & ~ADDR_CLEAR_MASK;
        b0 = '0;
        b1 = '0;
        b2 = '0;
        p.hit = 1'b1;
        case (reg_id)
            REG_TEX_SIZE: begin
                b0 = {cfg.tex_format, s[19:16]};
                b1 = s[15:8];
                b2 = s[7:0];
            end
            REG_TEX_ZERO: begin
                b0 = '0;
            end
            REG_TEX_ADDR: begin
                b0 = a[28:21];
                b1 = a[20:13];
                b2 = a[12:5];
            end
            REG_WRAP_S: begin
                b0 = cfg.wrap_s_mode;
                b1 = {6'd0, w[9:8]};
                b2 = w[7:0];
            end
            REG_WRAP_T: begin
                b0 = cfg.wrap_t_mode;
                b1 = {6'd0, h[9:8]};
                b2 = h[7:0];
            end
            default: begin
                p.hit = 1'b0;
            end
        endcase
        case (idx)
            2'd0:    p.value = b0;
            2'd1:    p.value = b1;
            default: p.value = b2;
        endcase
        return p;
    endfunction

endpackage

>>> design/dltp_list_if.sv
// Stream interface that carries command list bytes into the patcher.
interface dltp_list_if;
    logic       valid;
    logic       ready;
    logic       list_begin;
    logic [7:0] list_byte;

    modport source (output valid, output list_begin, output list_byte, input ready);
    modport sink (input valid, input list_begin, input list_byte, output ready);
endinterface

>>> design/dltp_patch_if.sv
// Stream interface that carries patched bytes and their flags out of the patcher.
interface dltp_patch_if;
    logic       valid;
    logic       ready;
    logic [7:0] patched_byte;
    logic       was_rewritten;
    logic       ends_here;
    logic       after_end;

    modport source (output valid, output patched_byte, output was_rewritten,
                    output ends_here, output after_end, input ready);
    modport sink (input valid, input patched_byte, input was_rewritten,
                  input ends_here, input after_end, output ready);
endinterface

>>> design/dltp_cfg_regs.sv
// APB-style register bank holding the texture configuration.
module dltp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dltp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dltp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [dltp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output dltp_pkg::t_cfg                      o_cfg
);
    import dltp_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_format    <= '0;
            r_cfg.tex_width     <= 11'd1;
            r_cfg.tex_height    <= 11'd1;
            r_cfg.image_address <= '0;
            r_cfg.wrap_s_mode   <= '0;
            r_cfg.wrap_t_mode   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                CFG_TEX_FORMAT:    r_cfg.tex_format    <= pwdata[3:0];
                CFG_TEX_WIDTH:     r_cfg.tex_width     <= pwdata[10:0];
                CFG_TEX_HEIGHT:    r_cfg.tex_height    <= pwdata[10:0];
                CFG_IMAGE_ADDRESS: r_cfg.image_address <= pwdata;
                CFG_WRAP_S_MODE:   r_cfg.wrap_s_mode   <= pwdata[7:0];
                CFG_WRAP_T_MODE:   r_cfg.wrap_t_mode   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            CFG_TEX_FORMAT:    prdata = {28'd0, r_cfg.tex_format};
            CFG_TEX_WIDTH:     prdata = {21'd0, r_cfg.tex_width};
            CFG_TEX_HEIGHT:    prdata = {21'd0, r_cfg.tex_height};
            CFG_IMAGE_ADDRESS: prdata = r_cfg.image_address;
            CFG_WRAP_S_MODE:   prdata = {24'd0, r_cfg.wrap_s_mode};
            CFG_WRAP_T_MODE:   prdata = {24'd0, r_cfg.wrap_t_mode};
            default:           prdata = '0;
        endcase
    end

endmodule

>>> design/dltp_parser.sv
// Command parser state and single-pass byte rewrite for one list byte.
module dltp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dltp_pkg::t_cfg       i_cfg,
    input  logic                 i_step,
    input  logic                 i_list_begin,
    input  logic [7:0]           i_list_byte,
    output dltp_pkg::t_result    o_result
);
    import dltp_pkg::*;

    logic [COUNT_W-1:0] r_bytes_left, n_bytes_left;
    logic               r_in_reg_write, n_in_reg_write;
    logic [7:0]         r_register_id, n_register_id;
    logic [MARK_W-1:0]  r_patch_marks, n_patch_marks;
    logic               r_stopped, n_stopped;

    logic [COUNT_W-1:0] cur_left;
    logic               cur_irw;
    logic [7:0]         cur_rid;
    logic [MARK_W-1:0]  cur_marks;
    logic               cur_stopped;
    logic [COUNT_W-1:0] dec_left;
    logic [1:0]         pay_idx;
    t_patch             patch;
    t_result            res;

    // A list start clears the parser before this byte is looked at.
    assign cur_left    = i_list_begin ? '0 : r_bytes_left;
    assign cur_irw     = i_list_begin ? 1'b0 : r_in_reg_write;
    assign cur_rid     = i_list_begin ? '0 : r_register_id;
    assign cur_marks   = i_list_begin ? '0 : r_patch_marks;
    assign cur_stopped = i_list_begin ? 1'b0 : r_stopped;
    assign dec_left    = cur_left - 4'd1;
    assign pay_idx     = 2'(POS_PAYLOAD - cur_left);
    assign patch       = payload_byte(i_cfg, cur_rid, pay_idx);

    always_comb begin
        n_bytes_left      = cur_left;
        n_in_reg_write    = cur_irw;
        n_register_id     = cur_rid;
        n_patch_marks     = cur_marks;
        n_stopped         = cur_stopped;
        res.patched_byte  = i_list_byte;
        res.was_rewritten = 1'b0;
        res.ends_here     = 1'b0;
        res.after_end     = 1'b0;
        if (cur_stopped) begin
            res.after_end = 1'b1;
        end else if (cur_left == '0) begin
            n_in_reg_write = 1'b0;
            case (i_list_byte)
                OP_NOP: ;
                OP_CMD6: n_bytes_left = LEN_CMD6;
                OP_CMD9: n_bytes_left = LEN_CMD9;
                OP_REG_WRITE: begin
                    n_bytes_left   = LEN_REG_WRITE;
                    n_in_reg_write = 1'b1;
                end
                default: begin
                    n_stopped     = 1'b1;
                    res.ends_here = 1'b1;
                end
            endcase
        end else begin
            if (cur_irw && cur_left == POS_REG_ID) begin
                n_register_id = i_list_byte;
                if (i_list_byte == REG_STOP && cur_marks != '0) begin
                    n_stopped     = 1'b1;
                    res.ends_here = 1'b1;
                end else begin
                    n_patch_marks = cur_marks | mark_of(i_list_byte);
                end
            end else if (cur_irw && cur_left <= POS_PAYLOAD && patch.hit) begin
                res.patched_byte  = patch.value;
                res.was_rewritten = 1'b1;
            end
            n_bytes_left = dec_left;
            if (dec_left == '0) begin
                n_in_reg_write = 1'b0;
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left   <= '0;
            r_in_reg_write <= 1'b0;
            r_register_id  <= '0;
            r_patch_marks  <= '0;
            r_stopped      <= 1'b0;
        end else if (i_step) begin
            r_bytes_left   <= n_bytes_left;
            r_in_reg_write <= n_in_reg_write;
            r_register_id  <= n_register_id;
            r_patch_marks  <= n_patch_marks;
            r_stopped      <= n_stopped;
        end
    end

endmodule

>>> design/display_list_texture_patcher.sv
// Top level of the display list texture patcher: input register, parser and result register.
// The block takes one command list byte per cycle and returns one byte per cycle while the
// output is not stalled by o_patch.ready; each byte passes through the input register and then
// the result register, with the parser working on it in between.
// Texture size, format, address and wrap values come from the APB registers, which the user
// must write only while no byte is in flight; the block itself does not enforce this.
module display_list_texture_patcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dltp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dltp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [dltp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    dltp_list_if.sink                           i_list,
    dltp_patch_if.source                        o_patch
);
    import dltp_pkg::*;

    t_cfg       cfg;
    t_result    parse_res;
    logic       r_in_valid;
    logic       r_begin;
    logic [7:0] r_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       out_adv;
    logic       step;

    dltp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign out_adv      = !r_out_valid || o_patch.ready;
    assign step         = r_in_valid && out_adv;
    assign i_list.ready = !r_in_valid || out_adv;

    dltp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_step       (step),
        .i_list_begin (r_begin),
        .i_list_byte  (r_byte),
        .o_result     (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_list.ready) begin
            r_in_valid <= i_list.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_list.ready && i_list.valid) begin
            r_begin <= i_list.list_begin;
            r_byte  <= i_list.list_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= parse_res;
        end
    end

    assign o_patch.valid         = r_out_valid;
    assign o_patch.patched_byte  = r_out.patched_byte;
    assign o_patch.was_rewritten = r_out.was_rewritten;
    assign o_patch.ends_here     = r_out.ends_here;
    assign o_patch.after_end     = r_out.after_end;

`ifndef SYNTHESIS
    a_rewrite_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.was_rewritten && r_out.ends_here))
        else $error("rewritten byte also flagged as end of parsing");

    a_after_end_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.after_end) |-> (!r_out.was_rewritten && !r_out.ends_here))
        else $error("byte after end of parsing was rewritten or flagged as end");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_adv) |=> (r_in_valid && $stable(r_byte) && $stable(r_begin)))
        else $error("input register lost a byte while the result register was stalled");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for the display list texture patcher: directed table, random lists.
`timescale 1ns / 1ps

module tb;
    import dltp_pkg::*;

    typedef struct packed {
        logic       first;
        logic [7:0] data;
        logic       typed;
        t_result    want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    dltp_list_if  list_bus ();
    dltp_patch_if patch_bus ();

    display_list_texture_patcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_list  (list_bus),
        .o_patch (patch_bus)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_cfg       cfg_q;
    logic [3:0] parse_left;
    logic       parse_in_reg;
    logic [7:0] parse_reg_id;
    logic [4:0] parse_marks;
    logic       parse_stopped;

    t_result    awaited_bytes[$];
    logic       row_typed;
    t_result    row_want;
    int         mismatches;
    int         bytes_sent;
    logic       bursts_on;
    int         stall_left;

    function automatic t_result texture_step(input logic first, input logic [7:0] data);
        logic [9:0]  w_enc;
        logic [9:0]  h_enc;
        logic [31:0] addr;
        logic [23:0] pay;
        logic        hit;
        t_result     r;
        w_enc = cfg_q.tex_width[9:0] - 10'd1;
        h_enc = cfg_q.tex_height[9:0] - 10'd1;
        addr  = cfg_q.image_address & ~ADDR_CLEAR_MASK;
        r = '0;
        r.patched_byte = data;
        if (first) begin
            parse_left    = '0;
            parse_in_reg  = 1'b0;
            parse_reg_id  = '0;
            parse_marks   = '0;
            parse_stopped = 1'b0;
        end
        if (parse_stopped) begin
            r.after_end = 1'b1;
        end else if (parse_left == 4'd0) begin
            parse_in_reg = 1'b0;
            case (data)
                OP_NOP: ;
                OP_CMD6: parse_left = LEN_CMD6;
                OP_CMD9: parse_left = LEN_CMD9;
                OP_REG_WRITE: begin
                    parse_left   = LEN_REG_WRITE;
                    parse_in_reg = 1'b1;
                end
                default: begin
                    parse_stopped = 1'b1;
                    r.ends_here   = 1'b1;
                end
            endcase
        end else begin
            if (parse_in_reg && parse_left == POS_REG_ID) begin
                parse_reg_id = data;
                if (data == REG_STOP && parse_marks != '0) begin
                    parse_stopped = 1'b1;
                    r.ends_here   = 1'b1;
                end else begin
                    case (data)
                        REG_TEX_SIZE: parse_marks[MARK_TEX_SIZE] = 1'b1;
                        REG_TEX_ADDR: parse_marks[MARK_TEX_ADDR] = 1'b1;
                        REG_WRAP_S:   parse_marks[MARK_WRAP_S]   = 1'b1;
                        REG_WRAP_T:   parse_marks[MARK_WRAP_T]   = 1'b1;
                        REG_TEX_ZERO: parse_marks[MARK_TEX_ZERO] = 1'b1;
                        default: ;
                    endcase
                end
            end else if (parse_in_reg && parse_left <= POS_PAYLOAD) begin
                hit = 1'b1;
                pay = '0;
                case (parse_reg_id)
                    REG_TEX_SIZE: pay = {cfg_q.tex_format, h_enc, w_enc};
                    REG_TEX_ZERO: pay = '0;
                    REG_TEX_ADDR: pay = addr[28:5];
                    REG_WRAP_S:   pay = {cfg_q.wrap_s_mode, 6'd0, w_enc};
                    REG_WRAP_T:   pay = {cfg_q.wrap_t_mode, 6'd0, h_enc};
                    default:      hit = 1'b0;
                endcase
                if (hit) begin
                    r.patched_byte  = pay[8*parse_left-1 -: 8];
                    r.was_rewritten = 1'b1;
                end
            end
            parse_left = parse_left - 4'd1;
            if (parse_left == 4'd0) parse_in_reg = 1'b0;
        end
        return r;
    endfunction

    function automatic t_row directed_row(input int n);
        case (n)
            0:  return {1'b1, OP_NOP,       1'b1, OP_NOP,       3'b000};
            1:  return {1'b0, OP_CMD6,      1'b1, OP_CMD6,      3'b000};
            2:  return {1'b0, OP_REG_WRITE, 1'b1, OP_REG_WRITE, 3'b000};
            3:  return {1'b0, REG_TEX_SIZE, 1'b1, REG_TEX_SIZE, 3'b000};
            4:  return {1'b0, 8'hFF,        1'b0, 8'h00,        3'b000};
            5:  return {1'b0, REG_STOP,     1'b0, 8'h00,        3'b000};
            6:  return {1'b0, 8'h01,        1'b0, 8'h00,        3'b000};
            7:  return {1'b0, OP_REG_WRITE, 1'b1, OP_REG_WRITE, 3'b000};
            8:  return {1'b0, REG_TEX_ZERO, 1'b1, REG_TEX_ZERO, 3'b000};
            9:  return {1'b0, 8'hFF,        1'b1, 8'h00,        3'b100};
            10: return {1'b0, 8'hFF,        1'b1, 8'h00,        3'b100};
            11: return {1'b0, 8'hFF,        1'b1, 8'h00,        3'b100};
            12: return {1'b0, OP_REG_WRITE, 1'b1, OP_REG_WRITE, 3'b000};
            13: return {1'b0, REG_STOP,     1'b1, REG_STOP,     3'b010};
            14: return {1'b0, 8'hFF,        1'b1, 8'hFF,        3'b001};
            15: return {1'b1, OP_CMD9,      1'b1, OP_CMD9,      3'b000};
            16: return {1'b0, 8'h55,        1'b1, 8'h55,        3'b000};
            17: return {1'b1, OP_REG_WRITE, 1'b1, OP_REG_WRITE, 3'b000};
            18: return {1'b0, REG_STOP,     1'b1, REG_STOP,     3'b000};
            19: return {1'b0, 8'hFF,        1'b1, 8'hFF,        3'b000};
            20: return {1'b0, 8'hFF,        1'b1, 8'hFF,        3'b000};
            21: return {1'b0, 8'hFF,        1'b1, 8'hFF,        3'b000};
            22: return {1'b0, 8'hFE,        1'b1, 8'hFE,        3'b010};
            23: return {1'b0, OP_NOP,       1'b1, OP_NOP,       3'b001};
            24: return {1'b1, OP_REG_WRITE, 1'b1, OP_REG_WRITE, 3'b000};
            default: return '0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (patch_bus.valid && patch_bus.ready) begin
                got.patched_byte  = patch_bus.patched_byte;
                got.was_rewritten = patch_bus.was_rewritten;
                got.ends_here     = patch_bus.ends_here;
                got.after_end     = patch_bus.after_end;
                if (awaited_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected output transfer, byte %02h",
                                              got.patched_byte));
                end else begin
                    want = awaited_bytes.pop_front();
                    if (got.patched_byte !== want.patched_byte)
                        report_mismatch($sformatf("patched_byte: expected %02h, got %02h",
                                                  want.patched_byte, got.patched_byte));
                    if (got.was_rewritten !== want.was_rewritten)
                        report_mismatch($sformatf("was_rewritten: expected %b, got %b",
                                                  want.was_rewritten, got.was_rewritten));
                    if (got.ends_here !== want.ends_here)
                        report_mismatch($sformatf("ends_here: expected %b, got %b",
                                                  want.ends_here, got.ends_here));
                    if (got.after_end !== want.after_end)
                        report_mismatch($sformatf("after_end: expected %b, got %b",
                                                  want.after_end, got.after_end));
                end
            end
            if (list_bus.valid && list_bus.ready) begin
                want = texture_step(list_bus.list_begin, list_bus.list_byte);
                if (row_typed) want = row_want;
                awaited_bytes.push_back(want);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            patch_bus.ready <= 1'b0;
            stall_left--;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            patch_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            patch_bus.ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic first, input logic [7:0] data, input logic typed,
                             input t_result want);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            list_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        list_bus.valid      <= 1'b1;
        list_bus.list_begin <= first;
        list_bus.list_byte  <= data;
        row_typed = typed;
        row_want  = want;
        do @(posedge i_clk); while (!list_bus.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic push_random(input int count);
        repeat (count) push_byte(1'b0, 8'($urandom), 1'b0, '0);
    endtask

    function automatic logic [7:0] pick_register();
        case ($urandom_range(0, 6))
            0: return REG_TEX_SIZE;
            1: return REG_TEX_ZERO;
            2: return REG_TEX_ADDR;
            3: return REG_WRAP_S;
            4: return REG_WRAP_T;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_list();
        int         n_cmds;
        int         kind;
        logic [7:0] op;
        logic       first;
        first  = 1'b1;
        n_cmds = $urandom_range(1, 6);
        for (int c = 0; c < n_cmds; c++) begin
            kind = $urandom_range(0, 15);
            if (kind == 13) begin
                do op = 8'($urandom);
                while (op == OP_NOP || op == OP_CMD6 || op == OP_CMD9 || op == OP_REG_WRITE);
                push_byte(first, op, 1'b0, '0);
                push_random($urandom_range(0, 4));
                return;
            end else if (kind == 14) begin
                push_byte(first, 8'($urandom), 1'b0, '0);
            end else if (kind == 0) begin
                push_byte(first, OP_NOP, 1'b0, '0);
            end else if (kind <= 2) begin
                push_byte(first, OP_CMD6, 1'b0, '0);
                push_random(5);
            end else if (kind == 3) begin
                push_byte(first, OP_CMD9, 1'b0, '0);
                push_random(8);
            end else begin
                push_byte(first, OP_REG_WRITE, 1'b0, '0);
                if (kind == 15) begin
                    push_byte(1'b0, REG_STOP, 1'b0, '0);
                    push_random(3);
                end else if (kind == 12) begin
                    push_random($urandom_range(0, 3));
                    return;
                end else begin
                    push_byte(1'b0, pick_register(), 1'b0, '0);
                    push_random(3);
                end
            end
            first = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        case (idx)
            CFG_TEX_FORMAT:    cfg_q.tex_format    = value[3:0];
            CFG_TEX_WIDTH:     cfg_q.tex_width     = value[10:0];
            CFG_TEX_HEIGHT:    cfg_q.tex_height    = value[10:0];
            CFG_IMAGE_ADDRESS: cfg_q.image_address = value;
            CFG_WRAP_S_MODE:   cfg_q.wrap_s_mode   = value[7:0];
            CFG_WRAP_T_MODE:   cfg_q.wrap_t_mode   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic program_texture(input logic [3:0] fmt, input logic [10:0] w,
                                   input logic [10:0] h, input logic [31:0] addr,
                                   input logic [7:0] ws, input logic [7:0] wt);
        write_reg(CFG_TEX_FORMAT, {28'd0, fmt});
        write_reg(CFG_TEX_WIDTH, {21'd0, w});
        write_reg(CFG_TEX_HEIGHT, {21'd0, h});
        write_reg(CFG_IMAGE_ADDRESS, addr);
        write_reg(CFG_WRAP_S_MODE, {24'd0, ws});
        write_reg(CFG_WRAP_T_MODE, {24'd0, wt});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (awaited_bytes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        t_row row;
        int   goal;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        list_bus.valid      = 1'b0;
        list_bus.list_begin = 1'b0;
        list_bus.list_byte  = '0;
        patch_bus.ready     = 1'b0;
        row_typed           = 1'b0;
        row_want            = '0;
        mismatches          = 0;
        bytes_sent          = 0;
        stall_left          = 0;
        bursts_on           = 1'b1;
        cfg_q               = '0;
        cfg_q.tex_width     = 11'd1;
        cfg_q.tex_height    = 11'd1;
        parse_left          = '0;
        parse_in_reg        = 1'b0;
        parse_reg_id        = '0;
        parse_marks         = '0;
        parse_stopped       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < 25; n++) begin
            row = directed_row(n);
            push_byte(row.first, row.data, row.typed, row.want);
        end

        for (int phase = 0; phase < 6; phase++) begin
            list_bus.valid <= 1'b0;
            wait_drained();
            case (phase)
                0: program_texture(4'hF, 11'd1024, 11'd1024, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
                1: program_texture(4'h0, 11'd1, 11'd1, 32'h0000_0000, 8'h00, 8'h00);
                2: program_texture(4'($urandom), 11'd0, 11'd2047, $urandom,
                                   8'($urandom), 8'($urandom));
                default: program_texture(4'($urandom), 11'($urandom_range(0, 2047)),
                                         11'($urandom_range(1, 1024)), $urandom,
                                         8'($urandom), 8'($urandom));
            endcase
            if (phase == 5) bursts_on = 1'b0;
            goal = bytes_sent + 56;
            while (bytes_sent < goal) send_list();
        end

        list_bus.valid <= 1'b0;
        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
design/dltp_pkg.sv
design/dltp_list_if.sv
design/dltp_patch_if.sv
design/dltp_cfg_regs.sv
design/dltp_parser.sv
design/display_list_texture_patcher.sv
dv/tb.sv
